// ----- rtl/ses_pkg.sv -----
// Shared types, constants and control codes of the equal-range search block.
package ses_pkg;

	localparam int DEPTH_DEF = 1024;  // default number of store entries
	localparam int CNT_W     = 11;    // count register width
	localparam int IDX_IN_W  = 10;    // entry index width on the input beat
	localparam int VAL_W     = 32;    // entry and target value width
	localparam int OUT_IDX_W = 11;    // result index width, all ones when absent
	localparam int FUNC_W    = 1;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT1,
		ST_SRCH1,
		ST_INIT2,
		ST_SRCH2,
		ST_DONE
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_target;  // capture the query target
		logic wr_entry;     // write beat accepted: store the entry
		logic init;         // set bounds to the whole range, issue first probe
		logic step;         // take the probe result, narrow bounds, issue next probe
		logic dir_first;    // narrow left on a match (first index search)
		logic save_first;   // keep the first search outcome
		logic load_out;     // move the result into the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_query;   // func of the waiting input beat
		logic more_init;  // searched range is not empty
		logic more_step;  // bounds still enclose a probe after this step
		logic hit_vld;    // the current search has matched
		logic out_busy;   // output register full and not being taken
	} sts_t;

endpackage

// ----- rtl/ses_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ses_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ses_ctrl.sv -----
// Controller state machine sequencing the two binary searches.
module ses_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ses_pkg::sts_t sts,
	output ses_pkg::cmd_t cmd
);

	ses_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ses_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ses_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.is_query) begin
						cmd.load_target = 1'b1;
						state_d         = ses_pkg::ST_INIT1;
					end else begin
						cmd.wr_entry = 1'b1;
					end
				end
			end
			ses_pkg::ST_INIT1: begin
				cmd.init      = 1'b1;
				cmd.dir_first = 1'b1;
				state_d       = sts.more_init ? ses_pkg::ST_SRCH1 : ses_pkg::ST_INIT2;
			end
			ses_pkg::ST_SRCH1: begin
				cmd.step      = 1'b1;
				cmd.dir_first = 1'b1;
				if (!sts.more_step) begin
					state_d = ses_pkg::ST_INIT2;
				end
			end
			ses_pkg::ST_INIT2: begin
				cmd.save_first = 1'b1;
				if (sts.hit_vld) begin
					cmd.init = 1'b1;
					state_d  = ses_pkg::ST_SRCH2;
				end else begin
					state_d = ses_pkg::ST_DONE;
				end
			end
			ses_pkg::ST_SRCH2: begin
				cmd.step = 1'b1;
				if (!sts.more_step) begin
					state_d = ses_pkg::ST_DONE;
				end
			end
			ses_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ses_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ses_pkg::ST_IDLE;
			end
		endcase
	end

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && sts.is_query) |=> (state_q == ses_pkg::ST_INIT1))
		else $error("query beat did not start the first search");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ses_pkg::ST_DONE && sts.out_busy) |=> (state_q == ses_pkg::ST_DONE))
		else $error("result dropped while output register busy");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.init && cmd.step))
		else $error("init and step issued together");

endmodule

// ----- rtl/ses_dp.sv -----
// Datapath: entry store, search bounds, probe compare and result register.
module ses_dp #(
	parameter int DEPTH = ses_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ses_pkg::cmd_t                 cmd,
	output ses_pkg::sts_t                 sts,
	input  logic                          in_valid,
	input  logic [ses_pkg::FUNC_W-1:0]    in_func,
	input  logic [ses_pkg::IDX_IN_W-1:0]  in_entry_index,
	input  logic [ses_pkg::VAL_W-1:0]     in_value,
	input  logic                          cfg_we,
	input  logic [ses_pkg::CNT_W-1:0]     cfg_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_found,
	output logic [ses_pkg::OUT_IDX_W-1:0] out_first_index,
	output logic [ses_pkg::OUT_IDX_W-1:0] out_last_index
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [ses_pkg::CNT_W-1:0] count_q;
	logic [ses_pkg::VAL_W-1:0] target_q;
	logic [CW-1:0]             low_q, hip_q;     // range is low .. hip-1
	logic [AW-1:0]             mid_q, hit_q, first_q;
	logic                      hit_vld_q, found_q;

	logic [CW-1:0]             n_sat, low_n, hip_n;
	logic [CW:0]               sum0, sum_n;
	logic [AW-1:0]             mid0, mid_n, rd_addr, wr_addr;
	logic [ses_pkg::VAL_W-1:0] rdata;
	logic                      eq, lt, wr_ok;
	logic [31:0]               cnt_w, idx_w, first_w, hit_w;

	// saturate the count to the store depth
	assign cnt_w = 32'(count_q);
	assign n_sat = (cnt_w > 32'(DEPTH)) ? CW'(DEPTH) : cnt_w[CW-1:0];

	assign idx_w   = 32'(in_entry_index);
	assign wr_ok   = idx_w < 32'(DEPTH);
	assign wr_addr = idx_w[AW-1:0];

	assign sum0 = {1'b0, n_sat} - (CW+1)'(1);
	assign mid0 = sum0[AW:1];

	assign eq = (rdata == target_q);
	assign lt = $signed(rdata) < $signed(target_q);

	// narrow right on less, or on a match in the last index search
	always_comb begin
		low_n = low_q;
		hip_n = hip_q;
		if (lt || (eq && !cmd.dir_first)) begin
			low_n = CW'(mid_q) + CW'(1);
		end else begin
			hip_n = CW'(mid_q);
		end
	end

	assign sum_n   = {1'b0, low_n} + {1'b0, hip_n} - (CW+1)'(1);
	assign mid_n   = sum_n[AW:1];
	assign rd_addr = cmd.init ? mid0 : mid_n;

	ses_ram #(
		.WIDTH (ses_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_entry && in_valid && wr_ok),
		.waddr (wr_addr),
		.wdata (in_value),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_target) begin
			target_q <= in_value;
		end
		if (cmd.init) begin
			low_q <= '0;
			hip_q <= n_sat;
			mid_q <= mid0;
		end else if (cmd.step) begin
			low_q <= low_n;
			hip_q <= hip_n;
			mid_q <= mid_n;
			if (eq) begin
				hit_q <= mid_q;
			end
		end
		if (cmd.save_first) begin
			first_q <= hit_q;
			found_q <= hit_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_vld_q <= 1'b0;
		end else if (cmd.init) begin
			hit_vld_q <= 1'b0;
		end else if (cmd.step && eq) begin
			hit_vld_q <= 1'b1;
		end
	end

	assign first_w = 32'(first_q);
	assign hit_w   = 32'(hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found       <= found_q;
			out_first_index <= found_q ? first_w[ses_pkg::OUT_IDX_W-1:0] : '1;
			out_last_index  <= (found_q && hit_vld_q) ? hit_w[ses_pkg::OUT_IDX_W-1:0] : '1;
		end
	end

	assign sts.is_query  = (in_func == ses_pkg::FUNC_QUERY);
	assign sts.more_init = (n_sat != '0);
	assign sts.more_step = (low_n < hip_n);
	assign sts.hit_vld   = hit_vld_q;
	assign sts.out_busy  = out_valid && !out_ready;

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (low_q <= CW'(mid_q) && CW'(mid_q) < hip_q && hip_q <= n_sat))
		else $error("probe outside search bounds");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("output register overwritten before taken");

	a_hit_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_vld_q) |-> $past(cmd.step && eq))
		else $error("match flag set without a matching probe");

endmodule

// ----- rtl/sorted_equal_range_search_top.sv -----
// Top level of the equal-range binary search over a loaded value store.
// Write beat: accepted while idle, and the next beat may follow at once.
// Query: two searches of P1 and P2 probes, P1 and P2 each at most ceil(log2(n+1)), n the
// searched count, P2 zero on a miss; one probe a cycle through the single registered read port.
// The next beat after a query is taken once its result enters the output register, later while
// the output register is still full; one query is in flight at a time. Reset (arst_n,
// asynchronous) idles the controller, empties the output and zeroes the count; the store is not
// cleared and holds no meaning until written.
module sorted_equal_range_search_top #(
	parameter int DEPTH = ses_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [9:0] entry_index, [41:10] value, rest zero
	input  logic [0:0]  s_axis_tuser,   // [0] func: 0 write entry, 1 query
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [10:0] first_index, [21:11] last_index, rest zero
	output logic [0:0]  m_axis_tuser,   // [0] found
	// count register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ses_pkg::CNT_W-1:0] cfg_data  // count_in_use
);

	ses_pkg::cmd_t cmd;
	ses_pkg::sts_t sts;

	logic [ses_pkg::OUT_IDX_W-1:0] first_index, last_index;

	// Change the count register only between queries; not enforced, cfg_ready stays high.
	assign cfg_ready = 1'b1;

	// Controller: hold input beats while a query runs, sequence both searches.
	ses_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: store, bounds, comparison and result register.
	ses_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_valid        (s_axis_tvalid),
		.in_func         (s_axis_tuser),
		.in_entry_index  (s_axis_tdata[9:0]),
		.in_value        (s_axis_tdata[41:10]),
		.cfg_we          (cfg_valid),
		.cfg_count       (cfg_data),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_found       (m_axis_tuser[0]),
		.out_first_index (first_index),
		.out_last_index  (last_index)
	);

	// Pack the result beat, upper bits zero.
	assign m_axis_tdata = {2'b00, last_index, first_index};

endmodule
